FILE: sv/bpc_pkg.sv
// Shared constants and types for the barometer compensation pipeline.
package bpc_pkg;

    localparam int DIV_W = 32;

    localparam logic [31:0] C_B6_OFFSET  = 32'd4000;
    localparam logic [31:0] C_X3_BIAS    = 32'd32768;
    localparam logic [31:0] C_B7_SCALE   = 32'd50000;
    localparam logic [31:0] C_P_MUL_A    = 32'd3038;
    localparam logic [31:0] C_P_MUL_B    = 32'd7357;
    localparam logic [31:0] C_P_OFFSET   = 32'd3791;

    localparam logic signed [31:0] C_T_MIN = -32'sd4096;
    localparam logic signed [31:0] C_T_MAX = 32'sd4095;
    localparam logic signed [31:0] C_P_MAX = 32'sd262143;

    typedef enum logic [2:0] {
        REG_OSS     = 3'd0,
        REG_AC123   = 3'd1,
        REG_AC456   = 3'd2,
        REG_B1B2    = 3'd3,
        REG_MCMD    = 3'd4
    } t_cfg_index;

endpackage

FILE: sv/bpc_div.sv
// Restoring unsigned divider, one quotient bit per pipeline stage.
module bpc_div
    import bpc_pkg::*;
#(
    parameter int W  = DIV_W,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_val  [W];
    logic [W-1:0]  r_rem  [W];
    logic [W-1:0]  r_num  [W];
    logic [W-1:0]  r_quo  [W];
    logic [W-1:0]  r_den  [W];
    logic [SW-1:0] r_side [W];

    logic          c_val  [W];
    logic [W-1:0]  c_rem  [W];
    logic [W-1:0]  c_num  [W];
    logic [W-1:0]  c_quo  [W];
    logic [W-1:0]  c_den  [W];
    logic [SW-1:0] c_side [W];

    logic [W:0]    n_try  [W];
    logic          n_ge   [W];

    always_comb begin
        c_val[0]  = i_valid;
        c_rem[0]  = '0;
        c_num[0]  = i_num;
        c_quo[0]  = '0;
        c_den[0]  = i_den;
        c_side[0] = i_side;
        for (int k = 1; k < W; k++) begin
            c_val[k]  = r_val[k-1];
            c_rem[k]  = r_rem[k-1];
            c_num[k]  = r_num[k-1];
            c_quo[k]  = r_quo[k-1];
            c_den[k]  = r_den[k-1];
            c_side[k] = r_side[k-1];
        end
        for (int k = 0; k < W; k++) begin
            n_try[k] = {c_rem[k], c_num[k][W-1]};
            n_ge[k]  = (n_try[k] >= {1'b0, c_den[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < W; k++) r_val[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < W; k++) r_val[k] <= c_val[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k]  <= n_ge[k] ? W'(n_try[k] - {1'b0, c_den[k]}) : n_try[k][W-1:0];
                r_num[k]  <= {c_num[k][W-2:0], 1'b0};
                r_quo[k]  <= {c_quo[k][W-2:0], n_ge[k]};
                r_den[k]  <= c_den[k];
                r_side[k] <= c_side[k];
            end
        end
    end

    assign o_valid = r_val[W-1];
    assign o_quo   = r_quo[W-1];
    assign o_side  = r_side[W-1];

endmodule

FILE: sv/barometer_temp_pressure_compensation_core.sv
// Barometer temperature and pressure compensation pipeline, top level.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+------------------------------------------
//  in      | i_in_valid   | o_in_ready   | i_raw_temperature, i_raw_pressure
//  out     | o_out_valid  | i_out_ready  | o_true_temperature, o_true_pressure,
//          |              |              | o_divide_fault
//  cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One transaction enters per cycle while not frozen; it passes stages 1 to 3, the
// temperature divider, stages 4 to 9, the pressure divider and stages 10 to 12.
// Reset clears the stage valid bits and all calibration registers to zero.
// When the output holds an untaken result, the whole pipeline freezes and input
// ready drops; nothing is lost or repeated.
module barometer_temp_pressure_compensation_core
    import bpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_raw_temperature,
    input  logic [18:0]        i_raw_pressure,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [12:0] o_true_temperature,
    output logic [17:0]        o_true_pressure,
    output logic               o_divide_fault,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    localparam int SA_W = 32 + 19 + 2;
    localparam int SB_W = 13 + 2;

    // Configuration registers.
    logic [1:0]  r_oss;
    logic [47:0] r_ac123, r_ac456;
    logic [31:0] r_b1b2, r_mcmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss   <= '0;
            r_ac123 <= '0;
            r_ac456 <= '0;
            r_b1b2  <= '0;
            r_mcmd  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                REG_OSS:   r_oss   <= i_cfg_data[1:0];
                REG_AC123: r_ac123 <= i_cfg_data;
                REG_AC456: r_ac456 <= i_cfg_data;
                REG_B1B2:  r_b1b2  <= i_cfg_data[31:0];
                REG_MCMD:  r_mcmd  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6, w_b1, w_b2, w_mc, w_md;
    assign w_ac1 = {{16{r_ac123[47]}}, r_ac123[47:32]};
    assign w_ac2 = {{16{r_ac123[31]}}, r_ac123[31:16]};
    assign w_ac3 = {{16{r_ac123[15]}}, r_ac123[15:0]};
    assign w_ac4 = {16'd0, r_ac456[47:32]};
    assign w_ac5 = {16'd0, r_ac456[31:16]};
    assign w_ac6 = {16'd0, r_ac456[15:0]};
    assign w_b1  = {{16{r_b1b2[31]}}, r_b1b2[31:16]};
    assign w_b2  = {{16{r_b1b2[15]}}, r_b1b2[15:0]};
    assign w_mc  = {{16{r_mcmd[31]}}, r_mcmd[31:16]};
    assign w_md  = {{16{r_mcmd[15]}}, r_mcmd[15:0]};

    logic w_en;
    logic r12_v;
    assign w_en       = !r12_v || i_out_ready;
    assign o_in_ready = w_en;

    // Stage 1: UT - AC6.
    logic        r1_v;
    logic [31:0] r1_d;
    logic [18:0] r1_up;
    // Stage 2: X1.
    logic        r2_v;
    logic [31:0] r2_x1;
    logic [18:0] r2_up;
    // Stage 3: divider operands as magnitudes.
    logic        r3_v, r3_neg, r3_fault;
    logic [31:0] r3_x1, r3_num, r3_den;
    logic [18:0] r3_up;

    logic [31:0] n3_den, n3_numsig;
    always_comb begin
        n3_den    = r2_x1 + w_md;
        n3_numsig = w_mc << 11;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_d     <= {16'd0, i_raw_temperature} - w_ac6;
            r1_up    <= i_raw_pressure;
            r2_x1    <= 32'($signed(r1_d * w_ac5) >>> 15);
            r2_up    <= r1_up;
            r3_x1    <= r2_x1;
            r3_up    <= r2_up;
            r3_num   <= n3_numsig[31] ? 32'(-n3_numsig) : n3_numsig;
            r3_den   <= n3_den[31] ? 32'(-n3_den) : n3_den;
            r3_neg   <= n3_numsig[31] ^ n3_den[31];
            r3_fault <= (n3_den == '0);
        end
    end

    logic               wa_v;
    logic [DIV_W-1:0]   wa_q;
    logic [SA_W-1:0]    wa_side;

    bpc_div #(.W(DIV_W), .SW(SA_W)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_side  ({r3_x1, r3_up, r3_neg, r3_fault}),
        .o_valid (wa_v),
        .o_quo   (wa_q),
        .o_side  (wa_side)
    );

    // Stage 4: B5, T, B6.
    logic        r4_v, r4_fault;
    logic [31:0] r4_b6;
    logic [12:0] r4_t;
    logic [18:0] r4_up;

    logic [31:0] n4_q, n4_b5, n4_traw;
    logic [12:0] n4_t;
    always_comb begin
        n4_q    = wa_side[1] ? 32'(-32'(wa_q)) : 32'(wa_q);
        n4_b5   = wa_side[SA_W-1 -: 32] + n4_q;
        n4_traw = 32'($signed(n4_b5 + 32'd8) >>> 4);
        if ($signed(n4_traw) < C_T_MIN)      n4_t = C_T_MIN[12:0];
        else if ($signed(n4_traw) > C_T_MAX) n4_t = C_T_MAX[12:0];
        else                                 n4_t = n4_traw[12:0];
    end

    // Stage 5 to 9 registers.
    logic        r5_v, r5_fault;
    logic [31:0] r5_sq, r5_p2, r5_p3;
    logic [12:0] r5_t;
    logic [18:0] r5_up;
    logic        r6_v, r6_fault;
    logic [31:0] r6_m1, r6_m2, r6_x2a, r6_x1b;
    logic [12:0] r6_t;
    logic [18:0] r6_up;
    logic        r7_v, r7_fault;
    logic [31:0] r7_b3, r7_xx;
    logic [12:0] r7_t;
    logic [18:0] r7_up;
    logic        r8_v, r8_fault;
    logic [31:0] r8_b4, r8_b7;
    logic [12:0] r8_t;
    logic        r9_v, r9_fault, r9_msb;
    logic [31:0] r9_num, r9_b4;
    logic [12:0] r9_t;

    logic [31:0] n6_s, n7_x1, n7_x3, n7_b3a, n7_x2, n7_x3b, n8_b4full;
    always_comb begin
        n6_s      = 32'($signed(r5_sq) >>> 12);
        n7_x1     = 32'($signed(r6_m2) >>> 11);
        n7_x3     = n7_x1 + r6_x2a;
        n7_b3a    = ((w_ac1 << 2) + n7_x3) << r_oss;
        n7_x2     = 32'($signed(r6_m1) >>> 16);
        n7_x3b    = 32'($signed(r6_x1b + n7_x2 + 32'd2) >>> 2);
        n8_b4full = w_ac4 * r7_xx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= wa_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_b6    <= n4_b5 - C_B6_OFFSET;
            r4_t     <= n4_t;
            r4_up    <= wa_side[20:2];
            r4_fault <= wa_side[0];

            r5_sq    <= r4_b6 * r4_b6;
            r5_p2    <= w_ac2 * r4_b6;
            r5_p3    <= w_ac3 * r4_b6;
            r5_t     <= r4_t;
            r5_up    <= r4_up;
            r5_fault <= r4_fault;

            r6_m1    <= w_b1 * n6_s;
            r6_m2    <= w_b2 * n6_s;
            r6_x2a   <= 32'($signed(r5_p2) >>> 11);
            r6_x1b   <= 32'($signed(r5_p3) >>> 13);
            r6_t     <= r5_t;
            r6_up    <= r5_up;
            r6_fault <= r5_fault;

            r7_b3    <= 32'($signed(n7_b3a + 32'd2) >>> 2);
            r7_xx    <= n7_x3b + C_X3_BIAS;
            r7_t     <= r6_t;
            r7_up    <= r6_up;
            r7_fault <= r6_fault;

            r8_b4    <= n8_b4full >> 15;
            r8_b7    <= ({13'd0, r7_up} - r7_b3) * (C_B7_SCALE >> r_oss);
            r8_t     <= r7_t;
            r8_fault <= r7_fault;

            // The B7 overflow branch divides first and doubles afterwards.
            r9_msb   <= r8_b7[31];
            r9_num   <= r8_b7[31] ? r8_b7 : (r8_b7 << 1);
            r9_b4    <= r8_b4;
            r9_t     <= r8_t;
            r9_fault <= r8_fault || (r8_b4 == '0);
        end
    end

    logic               wb_v;
    logic [DIV_W-1:0]   wb_q;
    logic [SB_W-1:0]    wb_side;

    bpc_div #(.W(DIV_W), .SW(SB_W)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r9_v),
        .i_num   (r9_num),
        .i_den   (r9_b4),
        .i_side  ({r9_t, r9_msb, r9_fault}),
        .o_valid (wb_v),
        .o_quo   (wb_q),
        .o_side  (wb_side)
    );

    // Stages 10 to 12: final pressure correction and saturation.
    logic        r10_v, r10_fault;
    logic [31:0] r10_p, r10_a2, r10_m;
    logic [12:0] r10_t;
    logic        r11_v, r11_fault;
    logic [31:0] r11_p, r11_x1, r11_x2;
    logic [12:0] r11_t;
    logic [12:0] r12_t;
    logic [17:0] r12_p;
    logic        r12_fault;

    logic [31:0] n10_p, n10_a, n11_x1m, n12_sum;
    always_comb begin
        n10_p   = wb_side[1] ? (32'(wb_q) << 1) : 32'(wb_q);
        n10_a   = 32'($signed(n10_p) >>> 8);
        n11_x1m = r10_a2 * C_P_MUL_A;
        n12_sum = r11_p + 32'($signed(r11_x1 + r11_x2 + C_P_OFFSET) >>> 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
        end else if (w_en) begin
            r10_v <= wb_v;
            r11_v <= r10_v;
            r12_v <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_p     <= n10_p;
            r10_a2    <= n10_a * n10_a;
            r10_m     <= C_P_MUL_B * n10_p;
            r10_t     <= wb_side[SB_W-1 -: 13];
            r10_fault <= wb_side[0];

            r11_x1    <= 32'($signed(n11_x1m) >>> 16);
            r11_x2    <= 32'($signed(32'd0 - r10_m) >>> 16);
            r11_p     <= r10_p;
            r11_t     <= r10_t;
            r11_fault <= r10_fault;

            r12_fault <= r11_fault;
            if (r11_fault) begin
                r12_t <= '0;
                r12_p <= '0;
            end else begin
                r12_t <= r11_t;
                if ($signed(n12_sum) < 0)            r12_p <= '0;
                else if ($signed(n12_sum) > C_P_MAX) r12_p <= C_P_MAX[17:0];
                else                                 r12_p <= n12_sum[17:0];
            end
        end
    end

    assign o_out_valid        = r12_v;
    assign o_true_temperature = $signed(r12_t);
    assign o_true_pressure    = r12_p;
    assign o_divide_fault     = r12_fault;

endmodule
